FILE: sv/scps_pkg.sv
// Package: states, register indexes, shape codes and plane order table.
package scps_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_SEND
  } state_t;

  localparam logic REG_SHAPE = 1'b0;
  localparam logic REG_ORDER = 1'b1;

  localparam logic [1:0] SHAPE_16X16     = 2'd0;
  localparam logic [1:0] SHAPE_8X8       = 2'd1;
  localparam logic [1:0] SHAPE_8X16      = 2'd2;
  localparam logic [1:0] SHAPE_16X16_ALT = 2'd3;

  localparam logic [1:0] ORD_HIGH_LOW   = 2'd0;
  localparam logic [1:0] ORD_LOW_HIGH   = 2'd1;
  localparam logic [1:0] ORD_LIGHT_DARK = 2'd2;
  localparam logic [1:0] ORD_DARK_LIGHT = 2'd3;

  localparam int NumPlanes = 15;

  typedef logic [7:0] pat_byte_t;
  typedef pat_byte_t [14:0] pat_row_t;

  function automatic logic [3:0] order_color(input logic [1:0] order, input logic [3:0] k);
    logic [3:0] tbl_hl [0:14];
    logic [3:0] tbl_ld [0:14];
    logic [3:0] c;
    tbl_hl = '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
               4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1};
    tbl_ld = '{4'd15, 4'd14, 4'd11, 4'd10, 4'd7, 4'd3, 4'd9, 4'd13,
               4'd5, 4'd8, 4'd2, 4'd12, 4'd6, 4'd4, 4'd1};
    c = 4'd1;
    if (k <= 4'd14) begin
      case (order)
        ORD_HIGH_LOW: c = tbl_hl[k];
        ORD_LOW_HIGH: c = tbl_hl[4'd14 - k];
        ORD_LIGHT_DARK: c = tbl_ld[k];
        ORD_DARK_LIGHT: c = tbl_ld[4'd14 - k];
        default: c = 4'd1;
      endcase
    end
    return c;
  endfunction

endpackage

FILE: sv/scps_row_if.sv
// Interface: one row word of eight 4-bit pixels.
interface scps_row_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_0;
  logic [3:0] pixel_1;
  logic [3:0] pixel_2;
  logic [3:0] pixel_3;
  logic [3:0] pixel_4;
  logic [3:0] pixel_5;
  logic [3:0] pixel_6;
  logic [3:0] pixel_7;

  modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3,
                  pixel_4, pixel_5, pixel_6, pixel_7, input ready);
  modport sink (input valid, pixel_0, pixel_1, pixel_2, pixel_3,
                pixel_4, pixel_5, pixel_6, pixel_7, output ready);
endinterface

FILE: sv/scps_chunk_if.sv
// Interface: one output word holding a 64-bit chunk of a color plane.
interface scps_chunk_if;
  logic        valid;
  logic        ready;
  logic [3:0]  plane_color;
  logic [3:0]  plane_slot;
  logic [1:0]  chunk_index;
  logic [63:0] pattern_chunk;
  logic        plane_done;
  logic        cell_done;
  logic        cell_empty;

  modport source (output valid, plane_color, plane_slot, chunk_index, pattern_chunk,
                  plane_done, cell_done, cell_empty, input ready);
  modport sink (input valid, plane_color, plane_slot, chunk_index, pattern_chunk,
                plane_done, cell_done, cell_empty, output ready);
endinterface

FILE: sv/sprite_color_plane_splitter.sv
// Top level: sprite color plane splitter with pattern store and plane sequencer.
//
// Rows are taken one per cycle while a cell loads; each row writes one pattern
// byte for all 15 colors into the pattern store. After the last row of the
// shape the block stops taking rows and a sequencer walks the selected
// priority order one color per cycle; for each color present it reads one
// 64-bit chunk per memory read and presents it, holding each word while the
// output stalls; the walk covers up to 15 order entries. A cell with no colors
// sends a single empty marker word instead. Row loading resumes once the last
// word of the cell is taken.
module sprite_color_plane_splitter (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic         wr_index,
  input  logic [1:0]   wr_data,
  scps_row_if.sink     row,
  scps_chunk_if.source chunk
);

  scps_pkg::state_t state, state_next;

  logic [1:0]  sprite_shape;
  logic [1:0]  priority_order;
  logic [5:0]  row_count;
  logic [14:0] colors_present;
  logic [14:0] pend;
  logic [3:0]  scan_k;
  logic [3:0]  cur_color;
  logic [3:0]  slot;
  logic [1:0]  ch;

  scps_pkg::pat_row_t mem [0:31];

  logic [3:0]  pix [0:7];
  scps_pkg::pat_row_t row_bytes;
  logic [14:0] row_mask;
  logic [14:0] colors_next;
  logic [5:0]  rows;
  logic [5:0]  rc_inc;
  logic [1:0]  last_chunk;
  logic        row_acc;
  logic        cell_end;
  logic [3:0]  scan_color;
  logic [3:0]  cur_idx;
  logic        scan_hit;
  logic [14:0] pend_left;
  logic        out_acc;

  assign pix[0] = row.pixel_0;
  assign pix[1] = row.pixel_1;
  assign pix[2] = row.pixel_2;
  assign pix[3] = row.pixel_3;
  assign pix[4] = row.pixel_4;
  assign pix[5] = row.pixel_5;
  assign pix[6] = row.pixel_6;
  assign pix[7] = row.pixel_7;

  always_comb begin
    for (int p = 0; p < scps_pkg::NumPlanes; p++) begin
      for (int x = 0; x < 8; x++) begin
        row_bytes[p][7 - x] = (pix[x] == 4'(p + 1));
      end
      row_mask[p] = |row_bytes[p];
    end
  end

  always_comb begin
    case (sprite_shape)
      scps_pkg::SHAPE_8X8: begin
        rows = 6'd8;
        last_chunk = 2'd0;
      end
      scps_pkg::SHAPE_8X16: begin
        rows = 6'd16;
        last_chunk = 2'd1;
      end
      default: begin
        rows = 6'd32;
        last_chunk = 2'd3;
      end
    endcase
  end

  assign row_acc     = row.valid && row.ready;
  assign out_acc     = chunk.valid && chunk.ready;
  assign rc_inc      = row_count + 6'd1;
  assign cell_end    = rc_inc >= rows;
  assign colors_next = colors_present | row_mask;
  assign scan_color  = scps_pkg::order_color(priority_order, scan_k);
  assign scan_hit    = pend[scan_color - 4'd1];
  assign cur_idx     = cur_color - 4'd1;
  assign pend_left   = pend & ~(15'd1 << cur_idx);

  always_comb begin
    state_next = state;
    case (state)
      scps_pkg::ST_IDLE: begin
        if (row_acc && cell_end) begin
          state_next = (colors_next == '0) ? scps_pkg::ST_SEND : scps_pkg::ST_SCAN;
        end
      end
      scps_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_next = scps_pkg::ST_READ;
        end
      end
      scps_pkg::ST_READ: state_next = scps_pkg::ST_SEND;
      scps_pkg::ST_SEND: begin
        if (out_acc) begin
          if (chunk.cell_done) begin
            state_next = scps_pkg::ST_IDLE;
          end else if (chunk.plane_done) begin
            state_next = scps_pkg::ST_SCAN;
          end else begin
            state_next = scps_pkg::ST_READ;
          end
        end
      end
      default: state_next = scps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    row.ready   = (state == scps_pkg::ST_IDLE);
    chunk.valid = (state == scps_pkg::ST_SEND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and cell bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_shape   <= 2'd0;
      priority_order <= 2'd0;
      row_count      <= 6'd0;
      colors_present <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          scps_pkg::REG_SHAPE: sprite_shape <= wr_data;
          scps_pkg::REG_ORDER: priority_order <= wr_data;
          default: ;
        endcase
      end
      if (row_acc) begin
        row_count      <= cell_end ? 6'd0 : rc_inc;
        colors_present <= cell_end ? 15'd0 : colors_next;
      end
    end
  end

  // Pattern store: one row word holding the byte of every plane per write.
  always_ff @(posedge clk) begin
    if (row_acc) begin
      mem[row_count[4:0]] <= row_bytes;
    end
  end

  // Sequencer datapath and output word.
  always_ff @(posedge clk) begin
    case (state)
      scps_pkg::ST_IDLE: begin
        if (row_acc && cell_end) begin
          pend   <= colors_next;
          scan_k <= 4'd0;
          slot   <= 4'd0;
          ch     <= 2'd0;
          chunk.plane_color   <= 4'd0;
          chunk.plane_slot    <= 4'd0;
          chunk.chunk_index   <= 2'd0;
          chunk.pattern_chunk <= 64'd0;
          chunk.plane_done    <= 1'b1;
          chunk.cell_done     <= 1'b1;
          chunk.cell_empty    <= 1'b1;
        end
      end
      scps_pkg::ST_SCAN: begin
        if (scan_hit) begin
          cur_color <= scan_color;
          ch        <= 2'd0;
        end else begin
          scan_k <= scan_k + 4'd1;
        end
      end
      scps_pkg::ST_READ: begin
        for (int b = 0; b < 8; b++) begin
          chunk.pattern_chunk[63 - 8 * b -: 8] <= mem[{ch, 3'(b)}][cur_idx];
        end
        chunk.plane_color <= cur_color;
        chunk.plane_slot  <= slot;
        chunk.chunk_index <= ch;
        chunk.plane_done  <= (ch == last_chunk);
        chunk.cell_done   <= (ch == last_chunk) && (pend_left == '0);
        chunk.cell_empty  <= 1'b0;
      end
      scps_pkg::ST_SEND: begin
        if (out_acc) begin
          if (chunk.plane_done) begin
            pend   <= pend_left;
            slot   <= slot + 4'd1;
            scan_k <= scan_k + 4'd1;
          end else begin
            ch <= ch + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    chunk.valid |-> !row.ready)
    else $error("row taken while a chunk word is pending");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    (chunk.valid && chunk.cell_empty) |-> (chunk.cell_done && chunk.plane_color == 4'd0))
    else $error("empty marker malformed");

  a_color_nonzero: assert property (@(posedge clk) disable iff (rst)
    (chunk.valid && !chunk.cell_empty) |-> (chunk.plane_color != 4'd0))
    else $error("plane word with transparent color");

  a_resume: assert property (@(posedge clk) disable iff (rst)
    (out_acc && chunk.cell_done) |=> row.ready)
    else $error("row port not reopened after cell end");

endmodule

FILE: sim/sprite_color_plane_splitter_test.sv
// Testbench: sprite color plane splitter, random rows checked against a plane predictor.
`timescale 1ns / 1ps

module sprite_color_plane_splitter_test;

  localparam int STORE_ROWS   = 32;
  localparam int LONG_HOLD    = 400;
  localparam int LIMIT_CYCLES = 300000;
  localparam int ROW_TARGET   = 300;

  localparam logic [3:0] PLANE_ORDER [4][15] = '{
    '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
      4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1},
    '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
      4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd15, 4'd14, 4'd11, 4'd10, 4'd7, 4'd3, 4'd9, 4'd13,
      4'd5, 4'd8, 4'd2, 4'd12, 4'd6, 4'd4, 4'd1},
    '{4'd1, 4'd4, 4'd6, 4'd12, 4'd2, 4'd8, 4'd5, 4'd13,
      4'd9, 4'd3, 4'd7, 4'd10, 4'd11, 4'd14, 4'd15}
  };

  localparam logic [1:0] PHASE_SHAPE [10] = '{
    scps_pkg::SHAPE_16X16, scps_pkg::SHAPE_8X8, scps_pkg::SHAPE_8X16,
    scps_pkg::SHAPE_16X16_ALT, scps_pkg::SHAPE_8X8, scps_pkg::SHAPE_8X16,
    scps_pkg::SHAPE_16X16, scps_pkg::SHAPE_8X8, scps_pkg::SHAPE_16X16_ALT,
    scps_pkg::SHAPE_8X16
  };
  localparam logic [1:0] PHASE_ORDER [10] = '{
    scps_pkg::ORD_HIGH_LOW, scps_pkg::ORD_LOW_HIGH, scps_pkg::ORD_LIGHT_DARK,
    scps_pkg::ORD_DARK_LIGHT, scps_pkg::ORD_DARK_LIGHT, scps_pkg::ORD_HIGH_LOW,
    scps_pkg::ORD_LIGHT_DARK, scps_pkg::ORD_LIGHT_DARK, scps_pkg::ORD_LOW_HIGH,
    scps_pkg::ORD_DARK_LIGHT
  };

  typedef logic [0:7][3:0] row_pix_t;

  typedef struct packed {
    logic [3:0]  color;
    logic [3:0]  slot;
    logic [1:0]  idx;
    logic [63:0] data;
    logic        plane_end;
    logic        cell_end;
    logic        empty;
  } plane_word_t;

  logic       clk;
  logic       rst;
  logic       wr_en;
  logic       wr_index;
  logic [1:0] wr_data;

  scps_row_if   row_ch ();
  scps_chunk_if word_ch ();

  sprite_color_plane_splitter uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .row      (row_ch.sink),
    .chunk    (word_ch.source)
  );

  // predictor state
  logic [7:0]  pat_store [15][STORE_ROWS];
  logic [14:0] seen_colors;
  logic [5:0]  rows_in;
  logic [1:0]  shape_reg;
  logic [1:0]  order_reg;

  row_pix_t    pending_rows [$];
  plane_word_t planned_words [$];

  int       rows_queued;
  int       rows_taken = 0;
  int       words_seen = 0;
  int       cells_seen = 0;
  int       empty_cells = 0;
  int       mismatches = 0;
  int       cycles = 0;
  int       src_idle_pct;
  int       snk_stall_pct;
  int       src_gap;
  int       snk_gap;
  int       hold_left;
  logic     calm;
  logic     long_hold_req;
  logic     long_hold_done;
  row_pix_t next_row;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int cell_rows(input logic [1:0] s);
    if (s == scps_pkg::SHAPE_8X8) return 8;
    if (s == scps_pkg::SHAPE_8X16) return 16;
    return STORE_ROWS;
  endfunction

  task automatic split_row(input row_pix_t px);
    int          rows_per_cell;
    int          row_at;
    int          chunks;
    int          slot;
    logic [7:0]  bytes_now [15];
    logic [3:0]  c;
    logic [63:0] w;
    plane_word_t e;
    rows_per_cell = cell_rows(shape_reg);
    row_at = int'(rows_in) % STORE_ROWS;
    for (int p = 0; p < 15; p++) bytes_now[p] = 8'h00;
    for (int x = 0; x < 8; x++) begin
      c = px[x];
      if (c != 4'd0) begin
        bytes_now[c - 1][7 - x] = 1'b1;
        seen_colors[c - 1] = 1'b1;
      end
    end
    for (int p = 0; p < 15; p++) pat_store[p][row_at] = bytes_now[p];
    rows_in = rows_in + 6'd1;
    if (int'(rows_in) < rows_per_cell) return;
    rows_in = 6'd0;
    if (seen_colors == 15'd0) begin
      e = '{color: 4'd0, slot: 4'd0, idx: 2'd0, data: 64'd0,
            plane_end: 1'b1, cell_end: 1'b1, empty: 1'b1};
      planned_words.push_back(e);
      return;
    end
    chunks = rows_per_cell / 8;
    slot = 0;
    for (int k = 0; k < 15; k++) begin
      c = PLANE_ORDER[order_reg][k];
      if (seen_colors[c - 1]) begin
        for (int ch = 0; ch < chunks; ch++) begin
          w = 64'd0;
          for (int b = 0; b < 8; b++) w = {w[55:0], pat_store[c - 1][ch * 8 + b]};
          e = '{color: c, slot: 4'(slot), idx: 2'(ch), data: w,
                plane_end: (ch + 1 == chunks), cell_end: 1'b0, empty: 1'b0};
          planned_words.push_back(e);
        end
        slot++;
      end
    end
    e = planned_words.pop_back();
    e.cell_end = 1'b1;
    planned_words.push_back(e);
    seen_colors = 15'd0;
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // row driver
  always @(posedge clk) begin
    if (rst) begin
      row_ch.valid <= 1'b0;
      src_gap <= 0;
      seen_colors = 15'd0;
      rows_in = 6'd0;
      for (int p = 0; p < 15; p++)
        for (int i = 0; i < STORE_ROWS; i++) pat_store[p][i] = 8'h00;
    end else begin
      if (row_ch.valid && row_ch.ready) begin
        split_row({row_ch.pixel_0, row_ch.pixel_1, row_ch.pixel_2, row_ch.pixel_3,
                   row_ch.pixel_4, row_ch.pixel_5, row_ch.pixel_6, row_ch.pixel_7});
        rows_taken++;
      end
      if (!row_ch.valid || row_ch.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          row_ch.valid <= 1'b0;
        end else if (pending_rows.size() == 0) begin
          row_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
          src_gap <= $urandom_range(0, 9);
          row_ch.valid <= 1'b0;
        end else begin
          next_row = pending_rows.pop_front();
          row_ch.pixel_0 <= next_row[0];
          row_ch.pixel_1 <= next_row[1];
          row_ch.pixel_2 <= next_row[2];
          row_ch.pixel_3 <= next_row[3];
          row_ch.pixel_4 <= next_row[4];
          row_ch.pixel_5 <= next_row[5];
          row_ch.pixel_6 <= next_row[6];
          row_ch.pixel_7 <= next_row[7];
          row_ch.valid <= 1'b1;
        end
      end
    end
  end

  // plane word monitor
  always @(posedge clk) begin
    plane_word_t e;
    if (rst) begin
      word_ch.ready <= 1'b0;
      snk_gap <= 0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        words_seen++;
        if (planned_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual color %0h chunk %0h",
                   $time, word_ch.plane_color, word_ch.pattern_chunk);
          mismatches++;
        end else begin
          e = planned_words.pop_front();
          check_field("plane_color", 64'(e.color), 64'(word_ch.plane_color));
          check_field("plane_slot", 64'(e.slot), 64'(word_ch.plane_slot));
          check_field("chunk_index", 64'(e.idx), 64'(word_ch.chunk_index));
          check_field("pattern_chunk", e.data, word_ch.pattern_chunk);
          check_field("plane_done", 64'(e.plane_end), 64'(word_ch.plane_done));
          check_field("cell_done", 64'(e.cell_end), 64'(word_ch.cell_done));
          check_field("cell_empty", 64'(e.empty), 64'(word_ch.cell_empty));
          if (e.cell_end) cells_seen++;
          if (e.empty) empty_cells++;
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        word_ch.ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        hold_left <= LONG_HOLD - 1;
        long_hold_done <= 1'b1;
        word_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        word_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < snk_stall_pct) begin
        snk_gap <= $urandom_range(0, 9);
        word_ch.ready <= 1'b0;
      end else begin
        word_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycles,
               planned_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_rows.size() != 0 || row_ch.valid || planned_words.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    if (idx == scps_pkg::REG_SHAPE) shape_reg = val;
    else order_reg = val;
    @(posedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_row(input row_pix_t r);
    pending_rows.push_back(r);
    rows_queued++;
  endtask

  task automatic push_cell(input int n_rows);
    int         style;
    int         n_pal;
    logic [3:0] pal [4];
    row_pix_t   r;
    style = $urandom_range(0, 9);
    n_pal = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) pal[i] = 4'($urandom_range(1, 15));
    for (int i = 0; i < n_rows; i++) begin
      for (int x = 0; x < 8; x++) begin
        if (style == 0) r[x] = 4'd0;
        else if (style >= 6) r[x] = 4'($urandom_range(0, 15));
        else if ($urandom_range(0, 3) == 0) r[x] = 4'd0;
        else r[x] = pal[$urandom_range(0, n_pal - 1)];
      end
      push_row(r);
    end
  endtask

  initial begin
    logic [1:0] shp;
    logic [1:0] ord;
    int         n_cells;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = scps_pkg::REG_SHAPE;
    wr_data = 2'd0;
    shape_reg = scps_pkg::SHAPE_16X16;
    order_reg = scps_pkg::ORD_HIGH_LOW;
    rows_queued = 0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    src_idle_pct = 20;
    snk_stall_pct = 20;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_reg(scps_pkg::REG_SHAPE, scps_pkg::SHAPE_8X8);
    set_reg(scps_pkg::REG_ORDER, scps_pkg::ORD_HIGH_LOW);
    // all transparent: empty marker
    repeat (8) push_row(32'h0000_0000);
    // every color, extremes of every pixel
    push_row(32'h1234_5678);
    push_row(32'h9ABC_DEF0);
    push_row(32'hFFFF_FFFF);
    push_row(32'h0000_0000);
    push_row(32'hF0F0_F0F0);
    push_row(32'h0101_0101);
    push_row(32'h8421_8421);
    push_row(32'h7654_321F);
    wait_idle();

    // shrink the shape in the middle of a cell
    set_reg(scps_pkg::REG_SHAPE, scps_pkg::SHAPE_8X16);
    set_reg(scps_pkg::REG_ORDER, scps_pkg::ORD_LIGHT_DARK);
    push_cell(10);
    wait_idle();
    set_reg(scps_pkg::REG_SHAPE, scps_pkg::SHAPE_8X8);
    push_row(32'hE00D_C00B);
    wait_idle();

    for (int ph = 0; rows_queued < ROW_TARGET; ph++) begin
      if (ph < 10) begin
        shp = PHASE_SHAPE[ph];
        ord = PHASE_ORDER[ph];
      end else begin
        shp = 2'($urandom_range(0, 3));
        ord = 2'($urandom_range(0, 3));
      end
      if (rows_queued >= ROW_TARGET - 50) calm = 1'b1;
      src_idle_pct = calm ? 0 : 10 * $urandom_range(0, 4);
      snk_stall_pct = calm ? 0 : 10 * $urandom_range(0, 4);
      wait_idle();
      set_reg(scps_pkg::REG_SHAPE, shp);
      set_reg(scps_pkg::REG_ORDER, ord);
      if (ph == 0) long_hold_req = 1'b1;
      n_cells = $urandom_range(1, 3);
      repeat (n_cells) push_cell(cell_rows(shp));
      // leave a partial cell to carry into the next setting
      if (!calm && $urandom_range(0, 2) == 0) push_cell($urandom_range(1, 7));
    end

    wait_idle();
    calm = 1'b1;
    set_reg(scps_pkg::REG_SHAPE, scps_pkg::SHAPE_8X8);
    set_reg(scps_pkg::REG_ORDER, scps_pkg::ORD_DARK_LIGHT);
    repeat (2) push_cell(8);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("Rows accepted: %0d, plane words checked: %0d, cells: %0d (%0d empty)",
             rows_taken, words_seen, cells_seen, empty_cells);
    $display("Shape codes and plane orders swept, with partial cells across shape changes");
    if (mismatches == 0 && planned_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words never seen", mismatches, planned_words.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/scps_pkg.sv
sv/scps_row_if.sv
sv/scps_chunk_if.sv
sv/sprite_color_plane_splitter.sv
sim/sprite_color_plane_splitter_test.sv
